/* rtl/r5dr_pkg.sv */
`timescale 1ns / 1ps

package r5dr_pkg;

  localparam int unsigned DEF_MAX_DISKS = 8;
  localparam int unsigned DEF_MAX_WORDS = 1024;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned SB_W      = 11;
  localparam int unsigned DC_W      = 4;
  localparam int unsigned DI_W      = 3;
  localparam int unsigned WI_W      = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BLK_W     = ADDR_W + SB_W + 1;
  localparam int unsigned DIV_STEPS = ADDR_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DC_W-1:0] DISK_COUNT_RST = DC_W'(2);
  localparam logic [SB_W-1:0] STRIPE_RST     = SB_W'(1);
  localparam logic [SB_W-1:0] WPD_RST        = SB_W'(1024);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISK_COUNT     = 2'd0,
    CFG_STRIPE_BLOCKS  = 2'd1,
    CFG_WORDS_PER_DISK = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_DIV2,
    S_DIV3,
    S_LOOK,
    S_ONE,
    S_XOR,
    S_XLAST,
    S_FIN
  } r5dr_state_e;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SB_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] quo;
    logic [SB_W-1:0]   rem;
  } div_rsp_t;

endpackage

/* rtl/r5dr_ram.sv */
`timescale 1ns / 1ps

module r5dr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/r5dr_div.sv */
`timescale 1ns / 1ps

module r5dr_div
  import r5dr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIV_STEPS - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SB_W-1:0]   rem_q, rem_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [SB_W-1:0]   dvs_q, dvs_d;

  logic [SB_W:0]     trial;
  logic [SB_W:0]     diff;
  logic              fits;

  assign trial = {rem_q, quo_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[SB_W-1:0] : trial[SB_W-1:0];
      quo_d = {quo_q[ADDR_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/raid5_degraded_read_core.sv */
// Load word: the result is registered in the output register on acceptance; next word then.
// Read word: the result reaches the output register after three 16-step passes of the
// shared restoring divider and, when the word is rebuilt, one memory read per disk. One
// word is in flight at a time; the next word is accepted once a read result is registered.
// Reset clears control state and present mask, sets config defaults; store words are kept.
`timescale 1ns / 1ps

module raid5_degraded_read_core
  import r5dr_pkg::*;
#(
  parameter int unsigned MAX_DISKS = DEF_MAX_DISKS,
  parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [DI_W-1:0]      disk_index_i,
  input  logic [WI_W-1:0]      word_index_i,
  input  logic [WORD_W-1:0]    word_data_i,
  input  logic [ADDR_W-1:0]    block_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic [WORD_W-1:0]    read_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SB_W-1:0]      cfg_data_i
);

  localparam int unsigned Depth = MAX_DISKS * MAX_WORDS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DW    = $clog2(MAX_DISKS);
  localparam int unsigned NW    = $clog2(MAX_DISKS + 1);

  r5dr_state_e state_q, state_d;

  logic [DC_W-1:0]      disk_count_q;
  logic [SB_W-1:0]      stripe_q;
  logic [SB_W-1:0]      wpd_q;
  logic [MAX_DISKS-1:0] present_q, present_d;

  logic [NW-1:0]        n_q, n_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [SB_W-1:0]      arem_q, arem_d;
  logic [NW-1:0]        col_q, col_d;
  logic [BLK_W-1:0]     blk_q, blk_d;
  logic [DW-1:0]        target_q, target_d;
  logic [DW-1:0]        j_q, j_d;
  logic                 pend_q, pend_d;
  logic                 res_status_q, res_status_d;
  logic [WORD_W-1:0]    res_data_q, res_data_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q, out_status_d;
  logic [WORD_W-1:0]    out_data_q, out_data_d;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WORD_W-1:0]    mem_rdata;

  logic                 out_free;
  logic                 in_acc;
  logic                 load_ok;
  logic                 chk_fail;
  logic                 blk_bad;
  logic                 tgt_present;
  logic                 degraded_ok;
  logic                 j_last;
  logic [31:0]          cap;
  logic [NW-1:0]        rowmod;
  logic [NW-1:0]        parity;
  logic [NW:0]          tsum;
  logic [NW:0]          tgt;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || ((func_i == FUNC_LOAD) && !out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign load_ok = (32'(disk_index_i) < MAX_DISKS) && (32'(word_index_i) < MAX_WORDS);

  assign cap      = 32'(wpd_q) * 32'(n_q - NW'(1));
  assign chk_fail = (n_q < NW'(2)) || (stripe_q == '0) || (32'(addr_q) >= cap);
  assign blk_bad  = (32'(blk_q) >= 32'(wpd_q)) || (32'(blk_q) >= MAX_WORDS);

  assign rowmod = NW'(div_rsp.rem);
  assign parity = n_q - NW'(1) - rowmod;
  assign tsum   = {1'b0, parity} + (NW + 1)'(1) + {1'b0, col_q};
  assign tgt    = (tsum >= {1'b0, n_q}) ? tsum - {1'b0, n_q} : tsum;

  assign tgt_present = present_q[target_q];
  assign j_last      = (NW'(j_q) == n_q - NW'(1));

  always_comb begin
    degraded_ok = 1'b1;
    for (int i = 0; i < MAX_DISKS; i++) begin
      if ((32'(i) < 32'(n_q)) && (32'(i) != 32'(target_q)) && !present_q[i]) begin
        degraded_ok = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func_i == FUNC_READ)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = chk_fail ? S_FIN : S_DIV1;
      S_DIV1: begin
        if (div_rsp.done) begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_d = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_rsp.done) begin
          state_d = blk_bad ? S_FIN : S_LOOK;
        end
      end
      S_LOOK: begin
        if (tgt_present) begin
          state_d = S_ONE;
        end else if (degraded_ok) begin
          state_d = S_XOR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ONE: state_d = S_FIN;
      S_XOR: begin
        if (j_last) begin
          state_d = S_XLAST;
        end
      end
      S_XLAST: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    present_d    = present_q;
    n_d          = n_q;
    addr_d       = addr_q;
    arem_d       = arem_q;
    col_d        = col_q;
    blk_d        = blk_q;
    target_d     = target_q;
    j_d          = j_q;
    pend_d       = 1'b0;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    div_req      = '0;
    mem_we       = 1'b0;
    mem_addr     = AW'(32'(disk_index_i) * MAX_WORDS + 32'(word_index_i));

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_LOAD) begin
            mem_we       = load_ok;
            out_valid_d  = 1'b1;
            out_status_d = 1'b0;
            out_data_d   = '0;
            for (int i = 0; i < MAX_DISKS; i++) begin
              if (load_ok && (32'(disk_index_i) == 32'(i))) begin
                present_d[i] = 1'b1;
              end
            end
          end else begin
            addr_d = block_address_i;
            n_d    = (32'(disk_count_q) > MAX_DISKS) ? NW'(MAX_DISKS) : NW'(disk_count_q);
          end
        end
      end
      S_CHECK: begin
        res_status_d = 1'b1;
        res_data_d   = '0;
        if (!chk_fail) begin
          div_req.start    = 1'b1;
          div_req.dividend = addr_q;
          div_req.divisor  = stripe_q;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          arem_d           = div_rsp.rem;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quo;
          div_req.divisor  = SB_W'(n_q - NW'(1));
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          col_d            = NW'(div_rsp.rem);
          blk_d            = BLK_W'(32'(div_rsp.quo) * 32'(stripe_q) + 32'(arem_q));
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quo;
          div_req.divisor  = SB_W'(n_q);
        end
      end
      S_DIV3: begin
        if (div_rsp.done) begin
          target_d = DW'(tgt);
        end
      end
      S_LOOK: begin
        mem_addr   = AW'(32'(target_q) * MAX_WORDS + 32'(blk_q));
        j_d        = '0;
        res_data_d = '0;
      end
      S_ONE: begin
        res_status_d = 1'b0;
        res_data_d   = mem_rdata;
      end
      S_XOR: begin
        mem_addr = AW'(32'(j_q) * MAX_WORDS + 32'(blk_q));
        pend_d   = (j_q != target_q);
        j_d      = j_q + DW'(1);
        if (pend_q) begin
          res_data_d = res_data_q ^ mem_rdata;
        end
      end
      S_XLAST: begin
        res_status_d = 1'b0;
        if (pend_q) begin
          res_data_d = res_data_q ^ mem_rdata;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      present_q    <= '0;
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
      disk_count_q <= DISK_COUNT_RST;
      stripe_q     <= STRIPE_RST;
      wpd_q        <= WPD_RST;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_DISK_COUNT:     disk_count_q <= cfg_data_i[DC_W-1:0];
          CFG_STRIPE_BLOCKS:  stripe_q     <= cfg_data_i;
          CFG_WORDS_PER_DISK: wpd_q        <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    addr_q       <= addr_d;
    arem_q       <= arem_d;
    col_q        <= col_d;
    blk_q        <= blk_d;
    target_q     <= target_d;
    j_q          <= j_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  r5dr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  r5dr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (word_data_i),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_data_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_DIV3))
    else $error("divider result outside a wait state");

  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE))
    else $error("store written during a read");

  a_rebuild_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XOR) |-> !present_q[target_q])
    else $error("rebuild of a present disk");

  a_fin_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> out_valid_q)
    else $error("finished read word lost");

endmodule

/* sim/raid5_degraded_read_core_tb.sv */
`timescale 1ns / 1ps

module raid5_degraded_read_core_tb;
  import r5dr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    func_e             func;
    logic [DI_W-1:0]   disk;
    logic [WI_W-1:0]   word;
    logic [WORD_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    bit                wait_drain;
  } array_cmd_t;

  typedef struct {
    logic              status;
    logic [WORD_W-1:0] data;
  } read_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic                 status_o;
  logic [WORD_W-1:0]    read_data_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DISK_COUNT;
  logic [SB_W-1:0]      cfg_data = '0;

  array_cmd_t cur = '{FUNC_LOAD, '0, '0, '0, '0, 1'b0};

  array_cmd_t access_q[$];
  read_word_t expected_reads_q[$];

  logic [WORD_W-1:0] shadow_disks[0:DEF_MAX_DISKS*DEF_MAX_WORDS-1];
  logic [7:0]        shadow_present = '0;
  logic [DC_W-1:0]   cfg_disks  = DISK_COUNT_RST;
  logic [SB_W-1:0]   cfg_stripe = STRIPE_RST;
  logic [SB_W-1:0]   cfg_wpd    = WPD_RST;

  bit              gen_written[0:DEF_MAX_DISKS*DEF_MAX_WORDS-1];
  logic [7:0]      gen_present = '0;
  logic [DC_W-1:0] gen_dc  = DISK_COUNT_RST;
  logic [SB_W-1:0] gen_sb  = STRIPE_RST;
  logic [SB_W-1:0] gen_wpd = WPD_RST;
  int unsigned     gen_pushed = 0;
  bit              drain_next = 1'b0;

  bit          in_taken = 1'b0;
  int unsigned accepted_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  read_word_t  want;

  raid5_degraded_read_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .func_i          (cur.func),
    .disk_index_i    (cur.disk),
    .word_index_i    (cur.word),
    .word_data_i     (cur.data),
    .block_address_i (cur.addr),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit locate_block(input logic [ADDR_W-1:0] addr,
                                      input logic [DC_W-1:0] dc,
                                      input logic [SB_W-1:0] sb,
                                      input logic [SB_W-1:0] wpd,
                                      output int unsigned n,
                                      output int unsigned blk,
                                      output int unsigned tgt);
    int unsigned d, stripe, row, col, parity;
    n = (dc > DEF_MAX_DISKS) ? DEF_MAX_DISKS : int'(dc);
    blk = 0;
    tgt = 0;
    if (n < 2 || sb == 0) return 1'b0;
    d = n - 1;
    if (int'(addr) >= int'(wpd) * d) return 1'b0;
    stripe = int'(addr) / int'(sb);
    row = stripe / d;
    col = stripe % d;
    blk = row * int'(sb) + int'(addr) % int'(sb);
    if (blk >= int'(wpd) || blk >= DEF_MAX_WORDS) return 1'b0;
    parity = d - row % n;
    tgt = (parity + 1 + col) % n;
    return 1'b1;
  endfunction

  function automatic read_word_t raid_access(array_cmd_t c);
    read_word_t r;
    int unsigned n, blk, tgt, cnt;
    logic [WORD_W-1:0] acc;
    r.status = 1'b0;
    r.data = '0;
    if (c.func == FUNC_LOAD) begin
      shadow_disks[c.disk * DEF_MAX_WORDS + c.word] = c.data;
      shadow_present[c.disk] = 1'b1;
      return r;
    end
    r.status = 1'b1;
    if (!locate_block(c.addr, cfg_disks, cfg_stripe, cfg_wpd, n, blk, tgt)) return r;
    if (shadow_present[tgt]) begin
      r.status = 1'b0;
      r.data = shadow_disks[tgt * DEF_MAX_WORDS + blk];
      return r;
    end
    cnt = 0;
    acc = '0;
    for (int j = 0; j < n; j++) begin
      if (shadow_present[j]) begin
        cnt++;
        acc ^= shadow_disks[j * DEF_MAX_WORDS + blk];
      end
    end
    if (cnt == n - 1) begin
      r.status = 1'b0;
      r.data = acc;
    end
    return r;
  endfunction

  function automatic array_cmd_t random_fields();
    array_cmd_t c;
    c.func = func_e'($urandom_range(1));
    c.disk = DI_W'($urandom_range(7));
    c.word = WI_W'($urandom_range(1023));
    c.data = $urandom;
    c.addr = ADDR_W'($urandom_range(16'hFFFF));
    c.wait_drain = drain_next;
    drain_next = 1'b0;
    return c;
  endfunction

  task automatic push_load(int unsigned d, int unsigned w, logic [WORD_W-1:0] v);
    array_cmd_t c;
    c = random_fields();
    c.func = FUNC_LOAD;
    c.disk = DI_W'(d);
    c.word = WI_W'(w);
    c.data = v;
    gen_written[d * DEF_MAX_WORDS + w] = 1'b1;
    gen_present[d] = 1'b1;
    access_q.push_back(c);
    gen_pushed++;
  endtask

  task automatic fill_word(int unsigned d, int unsigned blk);
    if (!gen_written[d * DEF_MAX_WORDS + blk]) push_load(d, blk, $urandom);
  endtask

  // preload every word the read will touch so nothing unwritten is read
  task automatic push_read(int unsigned addr);
    int unsigned n, blk, tgt, cnt;
    array_cmd_t c;
    if (locate_block(ADDR_W'(addr), gen_dc, gen_sb, gen_wpd, n, blk, tgt)) begin
      if (gen_present[tgt]) begin
        fill_word(tgt, blk);
      end else begin
        cnt = 0;
        for (int j = 0; j < n; j++) cnt += gen_present[j];
        if (cnt == n - 1) begin
          for (int j = 0; j < n; j++) if (gen_present[j]) fill_word(j, blk);
        end
      end
    end
    c = random_fields();
    c.func = FUNC_READ;
    c.addr = ADDR_W'(addr);
    access_q.push_back(c);
    gen_pushed++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (access_q.size() != 0 || in_valid || expected_reads_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SB_W'(val);
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  task automatic set_config(int unsigned dc, int unsigned sb, int unsigned wpd);
    wait_idle();
    write_reg(CFG_DISK_COUNT, dc);
    write_reg(CFG_STRIPE_BLOCKS, sb);
    write_reg(CFG_WORDS_PER_DISK, wpd);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    gen_dc = DC_W'(dc);
    gen_sb = SB_W'(sb);
    gen_wpd = SB_W'(wpd);
  endtask

  task automatic random_phase(int unsigned budget, int unsigned deg_dc);
    int unsigned dc, sb, wpd, n, cap, start, pick, d;
    bit marked;
    pick = $urandom_range(9);
    dc = (pick < 5) ? deg_dc : (pick < 8) ? $urandom_range(2, 8) : $urandom_range(15);
    pick = $urandom_range(9);
    sb = (pick < 7) ? $urandom_range(1, 8) : (pick < 9) ? $urandom_range(9, 2047) : 0;
    pick = $urandom_range(9);
    wpd = (pick < 8) ? $urandom_range(1, 48) : $urandom_range(49, 2047);
    set_config(dc, sb, wpd);
    n = (dc > DEF_MAX_DISKS) ? DEF_MAX_DISKS : dc;
    cap = (n >= 2) ? wpd * (n - 1) : 0;
    start = gen_pushed;
    marked = 1'b0;
    while (gen_pushed - start < budget) begin
      if (!marked && gen_pushed - start >= budget / 2) begin
        drain_next = 1'b1;
        marked = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        do d = $urandom_range(7);
        while (!gen_present[d]);
        push_load(d, $urandom_range(1023), $urandom);
      end else if (pick < 75 && cap > 0) begin
        push_read($urandom_range(cap - 1));
      end else if (pick < 90 && cap > 0) begin
        push_read(cap + $urandom_range(2) - 1);
      end else begin
        push_read($urandom_range(16'hFFFF));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (access_q.size() != 0
          && $urandom_range(99) >= ((accepted_items < 380) ? 10 :
                                    (accepted_items < 760) ? 52 : 0)
          && (!access_q[0].wait_drain || expected_reads_q.size() == 0)) begin
        cur <= access_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall <= rst_ni && ($urandom_range(99) < ((accepted_items < 380) ? 52 :
                                                  (accepted_items < 760) ? 10 : 0));
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid && !in_stall_o;
      if (in_taken) begin
        expected_reads_q.push_back(raid_access(cur));
        accepted_items++;
      end
      if (out_valid_o && !out_stall) begin
        if (expected_reads_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: status=%0d read_data=%h", status_o, read_data_o);
        end else begin
          want = expected_reads_q.pop_front();
          if (want.status !== status_o || want.data !== read_data_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp=%0d got=%0d, read_data exp=%h got=%h",
                       want.status, status_o, want.data, read_data_o);
          end
        end
      end
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          CFG_DISK_COUNT:     cfg_disks = cfg_data[DC_W-1:0];
          CFG_STRIPE_BLOCKS:  cfg_stripe = cfg_data;
          CFG_WORDS_PER_DISK: cfg_wpd = cfg_data;
          default: ;
        endcase
      end
      if (in_taken || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[raid5_degraded_read_core] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_read(0);
    push_load(0, 0, 32'hFFFF_FFFF);
    push_read(0);
    push_load(0, 1, 32'h0000_0000);
    push_read(1);
    push_read(1023);
    push_read(1024);
    push_read(16'hFFFF);
    push_load(7, 1023, 32'h0000_0000);
    push_load(0, 10'h2AA, 32'h5555_5555);
    set_config(0, 1, 1);
    push_read(0);
    set_config(1, 1, 1);
    push_read(0);
    set_config(15, 2047, 2047);
    push_read(0);
    push_read(2047);
    push_read(14328);
    push_read(14329);
    set_config(3, 0, 8);
    push_read(0);
    set_config(2, 1, 2047);
    push_read(1500);
    push_read(1023);
    set_config(3, 4, 6);
    push_read(8);
    push_read(10);

    // grow the array: degraded reads need exactly one disk missing
    push_load(1, $urandom_range(1023), $urandom);
    push_load(2, $urandom_range(1023), $urandom);
    repeat (12) random_phase(45, 4);
    push_load(3, $urandom_range(1023), $urandom);
    push_load(4, $urandom_range(1023), $urandom);
    push_load(5, $urandom_range(1023), $urandom);
    repeat (8) random_phase(45, $urandom_range(7, 8));
    push_load(6, $urandom_range(1023), $urandom);
    repeat (5) random_phase(45, 8);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    errors += expected_reads_q.size();
    if (errors == 0)
      $display("[raid5_degraded_read_core] OK");
    else
      $display("[raid5_degraded_read_core] ERROR");
    $finish;
  end

endmodule
